[hw/rtl/psd_pkg.sv]
package psd_pkg;

  // Field and datapath widths
  localparam int IN_W        = 16;
  localparam int FRAC_BITS   = 8;
  localparam int DIST_W      = 25;
  localparam int DIFF_W      = IN_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int QUO_W       = PROD_W + 2 * FRAC_BITS;
  localparam int NUM_W       = 2 * PROD_W + 2 * FRAC_BITS;
  localparam int ROOT_W      = (QUO_W + 1) / 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Which part of the segment is nearest
  typedef enum logic [1:0] {
    PART_INTERIOR = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2
  } part_t;

  // Division job; also the state of one divider stage
  // (hi = partial remainder, lo = numerator bits shifting out, quotient shifting in)
  typedef struct packed {
    logic [PROD_W-1:0] hi;
    logic [QUO_W-1:0]  lo;
    logic [PROD_W-1:0] den;
    part_t             part;
  } psd_job_t;

  // State of one square root stage
  typedef struct packed {
    logic [2*ROOT_W-1:0] val;
    logic [ROOT_W:0]     rem;
    logic [ROOT_W-1:0]   root;
    part_t               part;
  } psd_sq_t;

endpackage

[hw/rtl/point_segment_distance.sv]
// Channel  | Handshake       | Transfer when      | Payload
// ---------+-----------------+--------------------+---------------------------------------
// query    | push / full     | push && !full      | point_x/y, start_x/y, end_x/y (16b s)
// result   | pop / empty     | pop && !empty      | distance (25b u, 8 frac), nearest_part
//
// One query per cycle unless stalled; passes 4 front stages, the queue, 50 divider
// stages and 25 square root stages (one quotient or root bit per stage).
// Synchronous reset clears all valid bits and queue pointers; payload is not reset.
// A 4-entry queue sits between front and back: the front stalls only when it is full,
// the back stalls only while a result waits with pop low.
module point_segment_distance import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   point_x,
  input  logic [IN_W-1:0]   point_y,
  input  logic [IN_W-1:0]   start_x,
  input  logic [IN_W-1:0]   start_y,
  input  logic [IN_W-1:0]   end_x,
  input  logic [IN_W-1:0]   end_y,
  input  logic              push,
  output logic              full,
  output logic [DIST_W-1:0] distance,
  output logic [1:0]        nearest_part,
  output logic              empty,
  input  logic              pop
);

  logic                     fe_valid;
  psd_job_t                 fe_job;
  logic                     mid_full;
  logic                     mid_push;
  logic                     mid_empty;
  psd_job_t                 mid_job;
  logic                     mid_pop;
  logic                     back_en;
  logic                     div_valid;
  logic [QUO_W-1:0]         div_quo;
  part_t                    div_part;
  logic                     sq_valid;
  logic [ROOT_W-1:0]        sq_root;
  part_t                    sq_part;
  logic [ROOT_W+DIST_W-1:0] root_ext;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .point_x   (point_x),
    .point_y   (point_y),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .push      (push),
    .full      (full),
    .out_valid (fe_valid),
    .out_job   (fe_job),
    .out_ready (!mid_full)
  );

  assign mid_push = fe_valid && !mid_full;

  psd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (fe_job),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_job),
    .empty (mid_empty)
  );

  // Back pipeline advances unless the finished result is held
  assign back_en = !sq_valid || pop;
  assign mid_pop = back_en && !mid_empty;

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (!mid_empty),
    .in_job    (mid_job),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_part  (div_part)
  );

  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (div_valid),
    .in_val    (div_quo),
    .in_part   (div_part),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_part  (sq_part)
  );

  // Saturate root to the result width
  assign root_ext     = (ROOT_W+DIST_W)'(sq_root);
  assign distance     = (root_ext[ROOT_W+DIST_W-1:DIST_W] != '0) ? '1
                                                                 : root_ext[DIST_W-1:0];
  assign nearest_part = sq_part;
  assign empty        = !sq_valid;

  // Reset leaves both sides open and drained
  a_reset_clean: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not drained after reset");

  // Front only refuses queries when the middle queue is full
  a_full_cause: assert property (@(posedge clk) disable iff (rst) full |-> mid_full)
    else $error("front stalled without full queue");

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_full |-> !mid_push)
    else $error("push into full queue");

endmodule

[hw/rtl/psd_queue.sv]
module psd_queue import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  psd_job_t wdata,
  output logic     full,
  input  logic     pop,
  output psd_job_t rdata,
  output logic     empty
);

  psd_job_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

[hw/rtl/psd_front.sv]
module psd_front import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   point_x,
  input  logic [IN_W-1:0]   point_y,
  input  logic [IN_W-1:0]   start_x,
  input  logic [IN_W-1:0]   start_y,
  input  logic [IN_W-1:0]   end_x,
  input  logic [IN_W-1:0]   end_y,
  input  logic              push,
  output logic              full,
  output logic              out_valid,
  output psd_job_t          out_job,
  input  logic              out_ready
);

  logic en;
  logic v1, v2, v3, v4;

  // stage 1: differences
  logic signed [DIFF_W-1:0] pax, pay, pbx, pby, dx, dy;
  // stage 2: products
  logic signed [PROD_W-1:0] m_dxpax, m_dypay, m_dxpbx, m_dypby;
  logic signed [PROD_W-1:0] m_pax2, m_pay2, m_pbx2, m_pby2, m_dx2, m_dy2;
  logic signed [PROD_W-1:0] m_paxdy, m_paydx;
  // stage 3: sums
  logic signed [SUM_W-1:0]  dot1, dot2n;
  logic [PROD_W-1:0]        d1sq, d2sq, len2, cmag;
  logic signed [SUM_W-1:0]  cross_c;
  logic signed [SUM_W-1:0]  cross_abs;
  // stage 4: job
  logic [2*PROD_W-1:0]      c2;
  logic [NUM_W-1:0]         num;
  logic                     on_seg;
  psd_job_t                 job_c;
  psd_job_t                 job;

  // Whole front moves unless its last stage is held by a full queue
  assign en        = !v4 || out_ready;
  assign full      = !en;
  assign out_valid = v4;
  assign out_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: coordinate differences
  always_ff @(posedge clk) begin
    if (en) begin
      pax <= DIFF_W'(signed'(point_x)) - DIFF_W'(signed'(start_x));
      pay <= DIFF_W'(signed'(point_y)) - DIFF_W'(signed'(start_y));
      pbx <= DIFF_W'(signed'(point_x)) - DIFF_W'(signed'(end_x));
      pby <= DIFF_W'(signed'(point_y)) - DIFF_W'(signed'(end_y));
      dx  <= DIFF_W'(signed'(end_x)) - DIFF_W'(signed'(start_x));
      dy  <= DIFF_W'(signed'(end_y)) - DIFF_W'(signed'(start_y));
    end
  end

  // Stage 2: all products
  always_ff @(posedge clk) begin
    if (en) begin
      m_dxpax <= PROD_W'(dx) * PROD_W'(pax);
      m_dypay <= PROD_W'(dy) * PROD_W'(pay);
      m_dxpbx <= PROD_W'(dx) * PROD_W'(pbx);
      m_dypby <= PROD_W'(dy) * PROD_W'(pby);
      m_pax2  <= PROD_W'(pax) * PROD_W'(pax);
      m_pay2  <= PROD_W'(pay) * PROD_W'(pay);
      m_pbx2  <= PROD_W'(pbx) * PROD_W'(pbx);
      m_pby2  <= PROD_W'(pby) * PROD_W'(pby);
      m_dx2   <= PROD_W'(dx) * PROD_W'(dx);
      m_dy2   <= PROD_W'(dy) * PROD_W'(dy);
      m_paxdy <= PROD_W'(pax) * PROD_W'(dy);
      m_paydx <= PROD_W'(pay) * PROD_W'(dx);
    end
  end

  // Stage 3: dot products, squared lengths, cross magnitude
  always_comb begin
    cross_c   = SUM_W'(m_paxdy) - SUM_W'(m_paydx);
    cross_abs = cross_c[SUM_W-1] ? -cross_c : cross_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot1  <= SUM_W'(m_dxpax) + SUM_W'(m_dypay);
      dot2n <= SUM_W'(m_dxpbx) + SUM_W'(m_dypby);
      d1sq  <= $unsigned(m_pax2 + m_pay2);
      d2sq  <= $unsigned(m_pbx2 + m_pby2);
      len2  <= $unsigned(m_dx2 + m_dy2);
      cmag  <= cross_abs[PROD_W-1:0];
    end
  end

  // Stage 4: classify and build the division job
  always_comb begin
    c2     = (2*PROD_W)'(cmag) * (2*PROD_W)'(cmag);
    // second dot product is -dot2n, so it is non-negative when dot2n <= 0
    on_seg = !dot1[SUM_W-1] && (dot2n <= 0);
    job_c.den = PROD_W'(1);
    if (on_seg && (len2 != '0)) begin
      num        = NUM_W'(c2) << (2 * FRAC_BITS);
      job_c.den  = len2;
      job_c.part = PART_INTERIOR;
    end else if (on_seg || (d1sq < d2sq)) begin
      num        = NUM_W'(d1sq) << (2 * FRAC_BITS);
      job_c.part = PART_START;
    end else begin
      num        = NUM_W'(d2sq) << (2 * FRAC_BITS);
      job_c.part = PART_END;
    end
    job_c.hi = num[NUM_W-1:QUO_W];
    job_c.lo = num[QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) job <= job_c;
  end

endmodule

[hw/rtl/psd_div.sv]
module psd_div import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  psd_job_t         in_job,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output part_t            out_part
);

  psd_job_t st [QUO_W];
  logic     v  [QUO_W];

  // One restoring quotient bit per stage
  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    psd_job_t        src;
    psd_job_t        nxt;
    logic            src_v;
    logic [PROD_W:0] r2;
    logic [PROD_W:0] diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign src   = in_job;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st[i-1];
      assign src_v = v[i-1];
    end

    always_comb begin
      r2       = {src.hi, src.lo[QUO_W-1]};
      diff     = r2 - {1'b0, src.den};
      ge       = (r2 >= {1'b0, src.den});
      nxt      = src;
      nxt.hi   = ge ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
      nxt.lo   = {src.lo[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) v[i] <= 1'b0;
      else if (en) v[i] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (en) st[i] <= nxt;
    end
  end

  assign out_valid = v[QUO_W-1];
  assign out_quo   = st[QUO_W-1].lo;
  assign out_part  = st[QUO_W-1].part;

endmodule

[hw/rtl/psd_sqrt.sv]
module psd_sqrt import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QUO_W-1:0]  in_val,
  input  part_t             in_part,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output part_t             out_part
);

  psd_sq_t st [ROOT_W];
  logic    v  [ROOT_W];
  psd_sq_t init;

  always_comb begin
    init.val  = (2*ROOT_W)'(in_val);
    init.rem  = '0;
    init.root = '0;
    init.part = in_part;
  end

  // One root bit per stage, two radicand bits brought down each time
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    psd_sq_t           src;
    psd_sq_t           nxt;
    logic              src_v;
    logic [ROOT_W+2:0] r2;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign src   = init;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st[i-1];
      assign src_v = v[i-1];
    end

    always_comb begin
      r2       = {src.rem, src.val[2*ROOT_W-1 -: 2]};
      trial    = {1'b0, src.root, 2'b01};
      diff     = r2 - trial;
      ge       = (r2 >= trial);
      nxt      = src;
      nxt.rem  = ge ? diff[ROOT_W:0] : r2[ROOT_W:0];
      nxt.root = {src.root[ROOT_W-2:0], ge};
      nxt.val  = src.val << 2;
    end

    always_ff @(posedge clk) begin
      if (rst) v[i] <= 1'b0;
      else if (en) v[i] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (en) st[i] <= nxt;
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign out_root  = st[ROOT_W-1].root;
  assign out_part  = st[ROOT_W-1].part;

endmodule

[test/psd_checker.sv]
import psd_pkg::*;

module psd_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   point_x,
  input  logic [IN_W-1:0]   point_y,
  input  logic [IN_W-1:0]   start_x,
  input  logic [IN_W-1:0]   start_y,
  input  logic [IN_W-1:0]   end_x,
  input  logic [IN_W-1:0]   end_y,
  input  logic              push,
  input  logic              full,
  input  logic [DIST_W-1:0] distance,
  input  logic [1:0]        nearest_part,
  input  logic              empty,
  input  logic              pop,
  output int                errors,
  output int                pending,
  output int                results_seen,
  output int                interior_seen
);

  typedef struct packed {
    logic [DIST_W-1:0] dist_val;
    part_t             part;
  } distance_t;

  distance_t expected_dist_q[$];

  // Floor square root of a wide unsigned value, one bit pair per step
  function automatic logic [63:0] isqrt(input logic [127:0] val);
    logic [127:0] num;
    logic [127:0] res;
    logic [127:0] bitv;
    num  = val;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  // Exact distance from point to segment, FRAC_BITS fractional bits, floored
  function automatic distance_t seg_distance(
    input logic signed [IN_W-1:0] px, input logic signed [IN_W-1:0] py,
    input logic signed [IN_W-1:0] ax, input logic signed [IN_W-1:0] ay,
    input logic signed [IN_W-1:0] bx, input logic signed [IN_W-1:0] by
  );
    longint pax, pay, pbx, pby, dx, dy, dot_a, dot_b, cross_v, d2a, d2b, len2;
    logic [63:0]  cmag;
    logic [127:0] sq;
    logic [63:0]  root;
    distance_t    r;
    pax   = longint'(px) - longint'(ax);
    pay   = longint'(py) - longint'(ay);
    pbx   = longint'(px) - longint'(bx);
    pby   = longint'(py) - longint'(by);
    dx    = longint'(bx) - longint'(ax);
    dy    = longint'(by) - longint'(ay);
    dot_a = dx * pax + dy * pay;
    dot_b = -dx * pbx - dy * pby;
    d2a   = pax * pax + pay * pay;
    d2b   = pbx * pbx + pby * pby;
    len2  = dx * dx + dy * dy;
    if (dot_a >= 0 && dot_b >= 0) begin
      if (len2 == 0) begin
        // degenerate segment: plain distance to the start
        sq     = 128'(d2a) << (2 * FRAC_BITS);
        r.part = PART_START;
      end else begin
        cross_v = pax * dy - pay * dx;
        cmag    = (cross_v < 0) ? 64'(-cross_v) : 64'(cross_v);
        sq      = ((128'(cmag) * 128'(cmag)) << (2 * FRAC_BITS)) / 128'(len2);
        r.part  = PART_INTERIOR;
      end
    end else if (d2a < d2b) begin
      sq     = 128'(d2a) << (2 * FRAC_BITS);
      r.part = PART_START;
    end else begin
      sq     = 128'(d2b) << (2 * FRAC_BITS);
      r.part = PART_END;
    end
    root = isqrt(sq);
    if (root > 64'((1 << DIST_W) - 1)) r.dist_val = '1;
    else r.dist_val = root[DIST_W-1:0];
    return r;
  endfunction

  // Predict on query transfers, compare on result transfers
  always @(posedge clk) begin
    distance_t want;
    if (rst) begin
      errors        <= 0;
      pending       <= 0;
      results_seen  <= 0;
      interior_seen <= 0;
    end else begin
      if (push && !full)
        expected_dist_q.push_back(seg_distance(point_x, point_y, start_x, start_y,
                                               end_x, end_y));
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (nearest_part == PART_INTERIOR) interior_seen <= interior_seen + 1;
        if (expected_dist_q.size() == 0) begin
          if (errors < 10) $display("ERROR: result transfer with nothing expected");
          errors <= errors + 1;
        end else begin
          want = expected_dist_q.pop_front();
          if (want.dist_val !== distance || want.part !== nearest_part) begin
            if (errors < 10)
              $display("ERROR: distance exp %0d got %0d, part exp %0d got %0d",
                       want.dist_val, distance, want.part, nearest_part);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_dist_q.size();
    end
  end

endmodule

[test/tb_point_segment_distance.sv]
import psd_pkg::*;

module tb_point_segment_distance;

  localparam int MAX_CYCLES = 400000;
  localparam int LONG_HOLD  = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [IN_W-1:0]   point_x = '0, point_y = '0, start_x = '0, start_y = '0;
  logic [IN_W-1:0]   end_x = '0, end_y = '0;
  logic              push = 1'b0;
  logic              full;
  logic [DIST_W-1:0] distance;
  logic [1:0]        nearest_part;
  logic              empty;
  logic              pop = 1'b0;

  int errors, pending, results_seen, interior_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycle_cnt = 0;
  int   queries_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_segment_distance dut (.*);

  psd_checker chk (.*);

  // Receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_req && !hold_done) begin
      pop <= 1'b0;
      if (hold_left >= LONG_HOLD) hold_done <= 1'b1;
      hold_left <= hold_left + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One query transfer, with optional sender gaps before it
  task automatic send_query(input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
                            input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                            input logic [IN_W-1:0] bx, input logic [IN_W-1:0] by);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    point_x <= px; point_y <= py;
    start_x <= ax; start_y <= ay;
    end_x   <= bx; end_y   <= by;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    queries_sent++;
  endtask

  function automatic logic [IN_W-1:0] rand_coord(input int span);
    if (span >= 32768) return IN_W'($urandom);
    return IN_W'($urandom_range(2 * span) - span);
  endfunction

  function automatic logic [IN_W-1:0] near(input logic [IN_W-1:0] c, input int span);
    return IN_W'(int'($signed(c)) + $urandom_range(2 * span) - span);
  endfunction

  // Random query: shapes chosen so every case gets hit often
  task automatic random_query();
    logic [IN_W-1:0] ax, ay, bx, by, px, py;
    int span, kind;
    int sel;
    sel  = $urandom_range(3);
    span = (sel == 0) ? 32768 : (sel == 1) ? 1000 : (sel == 2) ? 30 : 4;
    kind = $urandom_range(9);
    ax = rand_coord(span); ay = rand_coord(span);
    bx = rand_coord(span); by = rand_coord(span);
    px = rand_coord(span); py = rand_coord(span);
    case (kind)
      0: begin bx = ax; by = ay; end                       // degenerate
      1: begin px = near(ax, 3); py = near(ay, 3); end     // around start
      2: begin px = near(bx, 3); py = near(by, 3); end     // around end
      3: begin                                             // near the midpoint
        px = IN_W'((int'($signed(ax)) + int'($signed(bx))) / 2 + $urandom_range(4) - 2);
        py = IN_W'((int'($signed(ay)) + int'($signed(by))) / 2 + $urandom_range(4) - 2);
      end
      4: begin                                             // axis-aligned segment
        by = ay;
      end
      5: begin                                             // extreme corners
        ax = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
        py = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      end
      default: ;
    endcase
    send_query(px, py, ax, ay, bx, by);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !empty) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and each geometric case
    send_query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_query(16'd3, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0);
    send_query(16'd5, 16'd7, 16'd0, 16'd0, 16'd10, 16'd0);
    send_query(16'hfffb, 16'd2, 16'd0, 16'd0, 16'd10, 16'd0);
    send_query(16'd15, 16'hfffe, 16'd0, 16'd0, 16'd10, 16'd0);
    send_query(16'd0, 16'd0, 16'd0, 16'd0, 16'd10, 16'd0);
    send_query(16'd10, 16'd0, 16'd0, 16'd0, 16'd10, 16'd0);
    send_query(16'd4, 16'd0, 16'd0, 16'd0, 16'd10, 16'd0);
    send_query(16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
    send_query(16'hffff, 16'hffff, 16'd0, 16'd0, 16'd1, 16'd1);
    send_query(16'd0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    send_query(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h00ff, 16'hff00);
    send_query(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'hff00, 16'h00ff);
    wait_drained();

    // Random phases: free flow, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 51) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 51) : 0;
      for (int i = 0; i < 300; i++) random_query();
      wait_drained();   // sender pauses until every result is back
    end

    // Long receiver hold-off while queries keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 120; i++) random_query();
    wait_drained();

    repeat (120) @(posedge clk);
    $display("Covered %0d queries, %0d results (%0d interior), four idle mixes",
             queries_sent, results_seen, interior_seen);
    $display("plus a long result hold-off that backed the queue up to the input.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
